// ===== rtl/rxd_pkg.sv =====
// Shared constants, a request type and a helper function of the receive ring drain unit.
package rxd_pkg;

    localparam int DATA_W     = 32;
    localparam int RING_SLOTS = 128;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int MAX_LANES  = 8;
    localparam int LANE_W     = $clog2(MAX_LANES);
    localparam int LANE_CNT_W = $clog2(MAX_LANES + 1);
    localparam int MODE_W     = 2;
    localparam int LCNT_W     = 4;
    localparam int LEN_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RING_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 2'd2;

    // Configuration reset values.
    localparam logic [MODE_W-1:0] MODE_RESET    = 2'd0;
    localparam logic [LCNT_W-1:0] LCNT_RESET    = 4'd1;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd9216;

    // Ring modes.
    localparam logic [MODE_W-1:0] MODE_INDEX = 2'd0;

    // Item opcodes.
    localparam logic OP_SYNC = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic              sub;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    // Number of lanes actually in use: one in index mode, otherwise the
    // requested count clamped to the valid range and floored to a power of two.
    function automatic logic [LANE_CNT_W-1:0] active_lanes(
        input logic [MODE_W-1:0] mode,
        input logic [LCNT_W-1:0] req
    );
        logic [LANE_CNT_W-1:0] lanes;
        int unsigned           v;
        lanes = LANE_CNT_W'(1);
        v     = int'(req);
        if (v == 0)
        begin
            v = 1;
        end
        if (v > MAX_LANES)
        begin
            v = MAX_LANES;
        end
        for (int k = 0; k < LANE_CNT_W; k++)
        begin
            if (v >= (1 << k))
            begin
                lanes = LANE_CNT_W'(1 << k);
            end
        end
        if (mode == MODE_INDEX)
        begin
            lanes = LANE_CNT_W'(1);
        end
        return lanes;
    endfunction

endpackage

// ===== rtl/rxd_alu.sv =====
// Shared 32-bit add/subtract unit with carry-out and zero detect.
module rxd_alu (
    input  rxd_pkg::alu_req_t            req,
    output logic [rxd_pkg::DATA_W:0]     res,
    output logic                         zero
);
    import rxd_pkg::*;

    // For a subtract, the top bit is the borrow of the unsigned difference.
    always_comb
    begin
        if (req.sub)
        begin
            res = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            res = {1'b0, req.a} + {1'b0, req.b};
        end
    end

    assign zero = (res[DATA_W-1:0] == '0);

endmodule

// ===== rtl/rxd_lane_file.sv =====
// Per-lane consumer index registers with one write port and one read port.
module rxd_lane_file (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [rxd_pkg::LANE_W-1:0]    waddr,
    input  logic [rxd_pkg::DATA_W-1:0]    wdata,
    input  logic [rxd_pkg::LANE_W-1:0]    raddr,
    output logic [rxd_pkg::DATA_W-1:0]    rdata
);
    import rxd_pkg::*;

    logic [DATA_W-1:0] lane_reg [MAX_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LANES; i++)
            begin
                lane_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            lane_reg[waddr] <= wdata;
        end
    end

    assign rdata = lane_reg[raddr];

endmodule

// ===== rtl/rx_ring_phase_drain_unit.sv =====
// Top level of the receive ring drain unit: sequencer, item registers and outputs.
//
//  channel   direction  transfer when             payload
//  -------   ---------  ------------------------  ----------------------------------------
//  item      in         start && !busy            opcode lane desc_len desc_phase
//                                                 producer_index base_index
//  result    out        done (one cycle)          slot_ready slot_index frame_len deliver
//                                                 publish consumer_index
//  config    in         cfg_we                    cfg_index cfg_data
//
// A sync item keeps the block busy while it seeds each of the N active lanes (1, 2,
// 4 or 8). A poll item reads its lane, tests the slot if the lane is in range, checks
// the length and advances the index if the slot is ready, then scans the N lanes for
// the minimum and publishes. The single lane file read port and the one shared
// add/subtract unit take these steps in turn, one lane of the scan per cycle.
// The result strobe done rises in the same cycle that busy falls, and the result ports
// hold their values until the next result. A new item may be started in that cycle.
// The receiver cannot stall, so nothing ever waits on the output side.
// Reset clears the lane indices, the published index, the control state and the
// configuration registers; the block accepts an item in the first cycle after reset is released.
module rx_ring_phase_drain_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Item channel.
    input  logic                             start,
    output logic                             busy,
    input  logic                             opcode,
    input  logic [2:0]                       lane,
    input  logic [31:0]                      desc_len,
    input  logic                             desc_phase,
    input  logic [31:0]                      producer_index,
    input  logic [31:0]                      base_index,
    // Result channel.
    output logic                             done,
    output logic                             slot_ready,
    output logic [6:0]                       slot_index,
    output logic [31:0]                      frame_len,
    output logic                             deliver,
    output logic                             publish,
    output logic [31:0]                      consumer_index,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [rxd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rxd_pkg::CFG_W-1:0]        cfg_data
);
    import rxd_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SYNC = 4'd1;
    localparam logic [3:0] S_READ = 4'd2;
    localparam logic [3:0] S_TEST = 4'd3;
    localparam logic [3:0] S_LEN  = 4'd4;
    localparam logic [3:0] S_ADV  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_PUB  = 4'd7;

    // Control state.
    logic [3:0]            state_reg, state_next;
    logic [LANE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DATA_W-1:0]     pub_reg, pub_next;

    // Configuration registers.
    logic [MODE_W-1:0]     mode_reg;
    logic [LCNT_W-1:0]     lcnt_reg;
    logic [LEN_W-1:0]      max_len_reg;

    // Item payload and working registers.
    logic [LANE_W-1:0]     lane_reg, lane_next;
    logic [DATA_W-1:0]     dlen_reg, dlen_next;
    logic                  phase_reg, phase_next;
    logic [DATA_W-1:0]     prod_reg, prod_next;
    logic [DATA_W-1:0]     base_reg, base_next;
    logic [LANE_CNT_W-1:0] n_reg, n_next;
    logic [DATA_W-1:0]     rc_reg, rc_next;
    logic                  in_range_reg, in_range_next;
    logic                  ok_reg, ok_next;
    logic                  dlv_reg, dlv_next;
    logic [DATA_W-1:0]     min_reg, min_next;

    // Result registers.
    logic                  o_ready_reg, o_ready_next;
    logic [SLOT_W-1:0]     o_slot_reg, o_slot_next;
    logic [DATA_W-1:0]     o_len_reg, o_len_next;
    logic                  o_dlv_reg, o_dlv_next;
    logic                  o_pub_reg, o_pub_next;

    // Lane file and shared unit connections.
    logic                  lf_we;
    logic [LANE_W-1:0]     lf_waddr;
    logic [LANE_W-1:0]     lf_raddr;
    logic [DATA_W-1:0]     lf_rdata;
    alu_req_t              alu_req;
    logic [DATA_W:0]       alu_res;
    logic                  alu_zero;
    logic [LANE_CNT_W-1:0] last_cnt;
    logic                  slot_ok;

    rxd_lane_file u_lane_file (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (lf_we),
        .waddr (lf_waddr),
        .wdata (alu_res[DATA_W-1:0]),
        .raddr (lf_raddr),
        .rdata (lf_rdata)
    );

    rxd_alu u_alu (
        .req  (alu_req),
        .res  (alu_res),
        .zero (alu_zero)
    );

    assign last_cnt = n_reg - LANE_CNT_W'(1);

    // The user must write the configuration only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            lcnt_reg    <= LCNT_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RING_MODE:  mode_reg    <= cfg_data[MODE_W-1:0];
                REG_LANE_COUNT: lcnt_reg    <= cfg_data[LCNT_W-1:0];
                REG_MAX_LEN:    max_len_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer. Each state issues at most one operation to the shared unit.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        pub_next      = pub_reg;
        lane_next     = lane_reg;
        dlen_next     = dlen_reg;
        phase_next    = phase_reg;
        prod_next     = prod_reg;
        base_next     = base_reg;
        n_next        = n_reg;
        rc_next       = rc_reg;
        in_range_next = in_range_reg;
        ok_next       = ok_reg;
        dlv_next      = dlv_reg;
        min_next      = min_reg;
        o_ready_next  = o_ready_reg;
        o_slot_next   = o_slot_reg;
        o_len_next    = o_len_reg;
        o_dlv_next    = o_dlv_reg;
        o_pub_next    = o_pub_reg;
        lf_we         = 1'b0;
        lf_waddr      = lane_reg;
        lf_raddr      = (state_reg == S_SCAN) ? cnt_reg[LANE_W-1:0] : lane_reg;
        alu_req       = '{sub: 1'b1, a: rc_reg, b: prod_reg};
        slot_ok       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lane_next     = lane;
                    dlen_next     = desc_len;
                    phase_next    = desc_phase;
                    prod_next     = producer_index;
                    // Header phase modes always sync the ring back to zero.
                    base_next     = mode_reg[1] ? '0 : base_index;
                    n_next        = active_lanes(mode_reg, lcnt_reg);
                    cnt_next      = '0;
                    ok_next       = 1'b0;
                    dlv_next      = 1'b0;
                    in_range_next = 1'b0;
                    state_next    = (opcode == OP_SYNC) ? S_SYNC : S_READ;
                end
            end

            S_SYNC:
            begin
                // Seed one lane per cycle at base plus its lane number.
                alu_req  = '{sub: 1'b0, a: base_reg, b: DATA_W'(cnt_reg)};
                lf_we    = 1'b1;
                lf_waddr = cnt_reg[LANE_W-1:0];
                if (cnt_reg == last_cnt)
                begin
                    pub_next     = base_reg;
                    o_ready_next = 1'b0;
                    o_slot_next  = '0;
                    o_len_next   = '0;
                    o_dlv_next   = 1'b0;
                    o_pub_next   = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + LANE_CNT_W'(1);
                end
            end

            S_READ:
            begin
                rc_next = lf_rdata;
                if ({1'b0, lane_reg} < n_reg)
                begin
                    in_range_next = 1'b1;
                    state_next    = S_TEST;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_TEST:
            begin
                // Index mode compares against the producer, phase modes check the
                // wrap bit of the lane index.
                alu_req = '{sub: 1'b1, a: rc_reg, b: prod_reg};
                if (mode_reg == MODE_INDEX)
                begin
                    slot_ok = !alu_zero;
                end
                else
                begin
                    slot_ok = (phase_reg == rc_reg[SLOT_W]);
                end
                ok_next = slot_ok;
                if (slot_ok)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_LEN:
            begin
                // A borrow from limit minus length means the frame is too long.
                alu_req    = '{sub: 1'b1, a: DATA_W'(max_len_reg), b: dlen_reg};
                dlv_next   = (dlen_reg != '0) && !alu_res[DATA_W];
                state_next = S_ADV;
            end

            S_ADV:
            begin
                alu_req    = '{sub: 1'b0, a: rc_reg, b: DATA_W'(n_reg)};
                lf_we      = 1'b1;
                lf_waddr   = lane_reg;
                cnt_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Wrapping minimum: a lane is smaller when its difference is negative.
                alu_req = '{sub: 1'b1, a: lf_rdata, b: min_reg};
                if (cnt_reg == '0)
                begin
                    min_next = lf_rdata;
                end
                else if (alu_res[DATA_W-1])
                begin
                    min_next = lf_rdata;
                end
                if (cnt_reg == last_cnt)
                begin
                    state_next = S_PUB;
                end
                else
                begin
                    cnt_next = cnt_reg + LANE_CNT_W'(1);
                end
            end

            S_PUB:
            begin
                alu_req      = '{sub: 1'b1, a: min_reg, b: pub_reg};
                o_pub_next   = !alu_zero;
                if (!alu_zero)
                begin
                    pub_next = min_reg;
                end
                o_ready_next = ok_reg;
                o_slot_next  = in_range_reg ? rc_reg[SLOT_W-1:0] : '0;
                o_len_next   = ok_reg ? dlen_reg : '0;
                o_dlv_next   = ok_reg && dlv_reg;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            pub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            pub_reg   <= pub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg     <= lane_next;
        dlen_reg     <= dlen_next;
        phase_reg    <= phase_next;
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        n_reg        <= n_next;
        rc_reg       <= rc_next;
        in_range_reg <= in_range_next;
        ok_reg       <= ok_next;
        dlv_reg      <= dlv_next;
        min_reg      <= min_next;
        o_ready_reg  <= o_ready_next;
        o_slot_reg   <= o_slot_next;
        o_len_reg    <= o_len_next;
        o_dlv_reg    <= o_dlv_next;
        o_pub_reg    <= o_pub_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign slot_ready     = o_ready_reg;
    assign slot_index     = o_slot_reg;
    assign frame_len      = o_len_reg;
    assign deliver        = o_dlv_reg;
    assign publish        = o_pub_reg;
    assign consumer_index = pub_reg;

    // A result is only strobed once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer busy");

    // An accepted item always makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // A delivered frame must come from a consumed slot with a nonzero length.
    a_deliver_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && o_dlv_reg) |-> (o_ready_reg && o_len_reg != '0))
        else $error("delivery without a consumed slot");

    // The lane scan and the lane seeding never run past the active lane count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SYNC) |-> cnt_reg < n_reg)
        else $error("lane counter beyond active lanes");

    // The published index only moves when a result reports it.
    a_pub_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !o_pub_reg) |-> $stable(pub_reg))
        else $error("published index moved without publish");

endmodule
